// ===== rtl/msfe_pkg.sv =====
// ----------------------------------------------------------------------------
// msfe_pkg
// Types and codes shared by the MAC set unit: request and response items,
// operation codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package msfe_pkg;

  localparam int unsigned MacW   = 48;
  localparam int unsigned CountW = 7;

  // Request operation codes; the unused code behaves as a query
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [MacW-1:0] mac;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [CountW-1:0] entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_APPEND,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_req;   // capture request, clear index and flags
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic rd_next;    // read at index+1 instead of index
    logic wr_shift;   // store read data at index
    logic wr_append;  // store request address at count
    logic cnt_inc;
    logic cnt_dec;
    logic set_hit;
    logic set_evict;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       idx_at_cnt;
    logic       next_lt_cnt;
    logic       match;
    logic       full;
  } sts_t;

endpackage

// ===== rtl/msfe_ram.sv =====
// ----------------------------------------------------------------------------
// msfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/msfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// msfe_ctrl
// Request sequencer: linear search, shift-down compaction, append, respond.
// ----------------------------------------------------------------------------
module msfe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  msfe_pkg::sts_t sts_i,
  output msfe_pkg::cmd_t cmd_o
);

  msfe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_o  = 1'b0;
    case (state_q)
      msfe_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          state_d        = msfe_pkg::ST_SRCH_RD;
        end
      end
      // issue read of the current slot, or finish search on a miss
      msfe_pkg::ST_SRCH_RD: begin
        if (sts_i.idx_at_cnt) begin
          if (sts_i.op == msfe_pkg::OP_ADD) begin
            if (sts_i.full) begin
              // evict the oldest: compact from slot zero first
              cmd_o.set_evict = 1'b1;
              cmd_o.idx_clr   = 1'b1;
              state_d         = msfe_pkg::ST_SH_RD;
            end else begin
              state_d = msfe_pkg::ST_APPEND;
            end
          end else begin
            state_d = msfe_pkg::ST_DONE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = msfe_pkg::ST_SRCH_CMP;
        end
      end
      msfe_pkg::ST_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.set_hit = 1'b1;
          // a remove compacts from the matching slot; index already there
          if (sts_i.op == msfe_pkg::OP_REMOVE) begin
            state_d = msfe_pkg::ST_SH_RD;
          end else begin
            state_d = msfe_pkg::ST_DONE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = msfe_pkg::ST_SRCH_RD;
        end
      end
      // move slot index+1 down to index until the young end
      msfe_pkg::ST_SH_RD: begin
        if (sts_i.next_lt_cnt) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = msfe_pkg::ST_SH_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          if (sts_i.op == msfe_pkg::OP_ADD) begin
            state_d = msfe_pkg::ST_APPEND;
          end else begin
            state_d = msfe_pkg::ST_DONE;
          end
        end
      end
      msfe_pkg::ST_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = msfe_pkg::ST_SH_RD;
      end
      msfe_pkg::ST_APPEND: begin
        cmd_o.wr_append = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        state_d         = msfe_pkg::ST_DONE;
      end
      msfe_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = msfe_pkg::ST_IDLE;
      end
      default: begin
        state_d = msfe_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != msfe_pkg::ST_IDLE);

endmodule

// ===== rtl/msfe_dpath.sv =====
// ----------------------------------------------------------------------------
// msfe_dpath
// Entry store, request registers, slot index, fill count and result flags.
// ----------------------------------------------------------------------------
module msfe_dpath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  msfe_pkg::req_t req_i,
  input  msfe_pkg::cmd_t cmd_i,
  output msfe_pkg::sts_t sts_o,
  output msfe_pkg::rsp_t rsp_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic [1:0]               op_q;
  logic [msfe_pkg::MacW-1:0] mac_q;
  logic [CntW-1:0]          idx_q, idx_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     hit_q, hit_d;
  logic                     evict_q, evict_d;
  logic [CntW-1:0]          idx_nxt;

  logic [AddrW-1:0]          raddr, waddr;
  logic [msfe_pkg::MacW-1:0] rdata, wdata;
  logic                      we;

  assign idx_nxt = idx_q + CntW'(1);

  // request capture (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= req_i.op;
      mac_q <= req_i.mac;
    end
  end

  // index, count and flag updates
  always_comb begin
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    hit_d   = hit_q;
    evict_d = evict_q;
    if (cmd_i.load_req || cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_nxt;
    end
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.load_req) begin
      hit_d   = 1'b0;
      evict_d = 1'b0;
    end else begin
      if (cmd_i.set_hit) begin
        hit_d = 1'b1;
      end
      if (cmd_i.set_evict) begin
        evict_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      cnt_q   <= '0;
      hit_q   <= 1'b0;
      evict_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      evict_q <= evict_d;
    end
  end

  // store port muxing: shift writes at index, append writes at count
  assign raddr = cmd_i.rd_next ? idx_nxt[AddrW-1:0] : idx_q[AddrW-1:0];
  assign waddr = cmd_i.wr_append ? cnt_q[AddrW-1:0] : idx_q[AddrW-1:0];
  assign wdata = cmd_i.wr_append ? mac_q : rdata;
  assign we    = cmd_i.wr_shift | cmd_i.wr_append;

  msfe_ram #(
    .Width (msfe_pkg::MacW),
    .Depth (CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // status back to the controller
  assign sts_o.op          = op_q;
  assign sts_o.idx_at_cnt  = (idx_q == cnt_q);
  assign sts_o.next_lt_cnt = (idx_nxt < cnt_q);
  assign sts_o.match       = (rdata == mac_q);
  assign sts_o.full        = (cnt_q == CntW'(CAPACITY));

  // count reported modulo 128
  assign rsp_o.hit         = hit_q;
  assign rsp_o.evicted     = evict_q;
  assign rsp_o.entry_count = msfe_pkg::CountW'(cnt_q);

endmodule

// ===== rtl/mac_set_fifo_evict_unit.sv =====
// ----------------------------------------------------------------------------
// mac_set_fifo_evict_unit
// Insertion-ordered set of MAC addresses with oldest-first eviction.
// ----------------------------------------------------------------------------
//  channel   ports                 handshake
//  request   req_i (req_t)         taken when start && !busy
//  response  rsp_o (rsp_t)         valid for one cycle with done_o
//
//  One request at a time. Search steps slot by slot from the oldest, reading a
//  slot and then comparing it; compaction reads slot index+1 and then writes it
//  at index for each entry moved; an add ends with an append. Search and shift
//  both go through the registered-read entry RAM. Worst case: an add to a full set.
//  Reset empties the set at once (entry RAM not cleared); the response cannot
//  be stalled, and busy drops the cycle after done_o.
// ----------------------------------------------------------------------------
module mac_set_fifo_evict_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  msfe_pkg::req_t req_i,
  output logic           done_o,
  output msfe_pkg::rsp_t rsp_o
);

  msfe_pkg::cmd_t cmd;
  msfe_pkg::sts_t sts;

  msfe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  msfe_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== dv/tb_mac_set_fifo_evict_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mac_set_fifo_evict_unit
// Self-checking bench for the insertion-ordered MAC set with oldest-first
// eviction. A table of directed requests covers the empty set, the all-zero
// and all-one addresses, every op code, duplicate adds, a fill to capacity
// and evictions. Random traffic follows, drawn mostly from a shared address
// pool so that adds, removes and queries collide. Each response is compared
// against the row's expected response where given, else a queue-based model.
// ----------------------------------------------------------------------------
module tb_mac_set_fifo_evict_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap           = 64;
  localparam int unsigned WatchdogLimit = 8 * (4 * Cap + 8);
  localparam int unsigned PoolSize      = 80;
  localparam int unsigned RandBlocks    = 7;
  localparam int unsigned BlockItems    = 90;
  localparam int unsigned NumDirRows    = 20;

  // The fourth op code is not in the enum; it acts as a query
  localparam logic [1:0]                OpUnused = 2'd3;
  localparam logic [msfe_pkg::MacW-1:0] MacOnes  = '1;
  localparam logic [msfe_pkg::MacW-1:0] MacFill  = 48'hAAAA_AAAA_AA00;
  localparam logic [msfe_pkg::MacW-1:0] MacAlt   = 48'h5555_5555_5555;
  localparam logic [msfe_pkg::MacW-1:0] MacLow   = 48'h0000_0000_0001;
  localparam logic [msfe_pkg::MacW-1:0] MacHigh  = 48'h8000_0000_0000;

  typedef struct {
    logic [1:0]                op;
    logic [msfe_pkg::MacW-1:0] mac;
    int unsigned               reps;    // mac increments on each repeat
    bit                        typed;   // rsp holds the expected response
    msfe_pkg::rsp_t            rsp;
  } dir_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  msfe_pkg::req_t req_i;
  logic           done_o;
  msfe_pkg::rsp_t rsp_o;

  // Expectation source for the item currently offered
  bit             row_typed;
  msfe_pkg::rsp_t row_rsp;

  // Model of the set: index 0 is the oldest address
  logic [msfe_pkg::MacW-1:0] stored_macs[$];
  msfe_pkg::rsp_t            pending_rsp[$];
  logic [msfe_pkg::MacW-1:0] mac_pool[PoolSize];
  dir_row_t                  dir_rows[NumDirRows];

  int unsigned errors;
  int unsigned idle_cycles;

  mac_set_fifo_evict_unit #(
    .CAPACITY(Cap)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Apply one request to the set model and return its response
  function automatic msfe_pkg::rsp_t apply_request(input msfe_pkg::req_t r);
    msfe_pkg::rsp_t res;
    int             pos;
    pos         = -1;
    res         = '0;
    foreach (stored_macs[i]) begin
      if (stored_macs[i] == r.mac) pos = i;
    end
    res.hit     = (pos >= 0);
    res.evicted = 1'b0;
    case (r.op)
      msfe_pkg::OP_ADD: begin
        if (pos < 0) begin
          if (stored_macs.size() >= Cap) begin
            void'(stored_macs.pop_front());
            res.evicted = 1'b1;
          end
          stored_macs.push_back(r.mac);
        end
      end
      msfe_pkg::OP_REMOVE: begin
        if (pos >= 0) stored_macs.delete(pos);
      end
      default: ;
    endcase
    res.entry_count = msfe_pkg::CountW'(stored_macs.size());
    return res;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item after an optional gap and hold it until it is taken
  task automatic issue(input msfe_pkg::req_t r, input bit typed,
                       input msfe_pkg::rsp_t typed_rsp, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    req_i     <= r;
    row_typed <= typed;
    row_rsp   <= typed_rsp;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
  endtask

  // Response check, then prediction for an item taken on this edge
  always @(posedge clk_i) begin
    msfe_pkg::rsp_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_rsp.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp_o.hit);
            errors++;
          end
          if (rsp_o.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, rsp_o.evicted);
            errors++;
          end
          if (rsp_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, rsp_o.entry_count);
            errors++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        want = apply_request(req_i);
        pending_rsp.push_back(row_typed ? row_rsp : want);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    msfe_pkg::req_t            rq;
    msfe_pkg::rsp_t            no_rsp;
    int unsigned               add_pct;
    int unsigned               r;
    bit                        quiet;
    logic [msfe_pkg::MacW-1:0] m;

    no_rsp      = '0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    row_typed   = 1'b0;
    row_rsp     = '0;

    dir_rows = '{
      // empty set: query, remove and the unused op code miss
      '{msfe_pkg::OP_QUERY,  48'h0,        1,      1'b1, '{1'b0, 1'b0, 7'd0}},
      '{msfe_pkg::OP_REMOVE, MacOnes,      1,      1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OpUnused,            48'h0,        1,      1'b1, '{1'b0, 1'b0, 7'd0}},
      // first add, duplicate add, all-ones address
      '{msfe_pkg::OP_ADD,    48'h0,        1,      1'b1, '{1'b0, 1'b0, 7'd1}},
      '{msfe_pkg::OP_ADD,    48'h0,        1,      1'b1, '{1'b1, 1'b0, 7'd1}},
      '{msfe_pkg::OP_ADD,    MacOnes,      1,      1'b1, '{1'b0, 1'b0, 7'd2}},
      '{msfe_pkg::OP_QUERY,  MacOnes,      1,      1'b1, '{1'b1, 1'b0, 7'd2}},
      '{OpUnused,            MacOnes,      1,      1'b1, '{1'b1, 1'b0, 7'd2}},
      // remove present, then absent
      '{msfe_pkg::OP_REMOVE, 48'h0,        1,      1'b1, '{1'b1, 1'b0, 7'd1}},
      '{msfe_pkg::OP_REMOVE, 48'h0,        1,      1'b1, '{1'b0, 1'b0, 7'd1}},
      // fill to capacity, then evict the oldest (all-ones)
      '{msfe_pkg::OP_ADD,    MacFill,      Cap - 1, 1'b0, no_rsp},
      '{msfe_pkg::OP_ADD,    MacAlt,       1,      1'b1, '{1'b0, 1'b1, 7'(Cap)}},
      '{msfe_pkg::OP_QUERY,  MacOnes,      1,      1'b1, '{1'b0, 1'b0, 7'(Cap)}},
      // remove from the middle, duplicate add, refill and evict again
      '{msfe_pkg::OP_REMOVE, MacFill + 20, 1,      1'b0, no_rsp},
      '{msfe_pkg::OP_ADD,    MacFill + 30, 1,      1'b0, no_rsp},
      '{msfe_pkg::OP_ADD,    MacLow,       1,      1'b0, no_rsp},
      '{msfe_pkg::OP_ADD,    MacHigh,      1,      1'b0, no_rsp},
      // remove at the old end and at the young end
      '{msfe_pkg::OP_REMOVE, MacFill + 1,  1,      1'b0, no_rsp},
      '{msfe_pkg::OP_REMOVE, MacHigh,      1,      1'b0, no_rsp},
      '{msfe_pkg::OP_QUERY,  MacAlt,       1,      1'b0, no_rsp}
    };

    foreach (mac_pool[i]) mac_pool[i] = msfe_pkg::MacW'({$urandom(), $urandom()});

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_rows[i]) begin
      for (int unsigned k = 0; k < dir_rows[i].reps; k++) begin
        rq.op  = dir_rows[i].op;
        rq.mac = dir_rows[i].mac + msfe_pkg::MacW'(k);
        issue(rq, dir_rows[i].typed && dir_rows[i].reps == 1, dir_rows[i].rsp,
              pick_gap(1'b0));
      end
    end

    // Random blocks, each with its own add bias and idling mode
    for (int unsigned b = 0; b < RandBlocks; b++) begin
      if (b == 0 || $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(negedge clk_i);
      end
      r       = $urandom_range(0, 2);
      add_pct = (r == 0) ? 85 : (r == 1) ? 55 : 25;
      quiet   = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < BlockItems; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          m = mac_pool[$urandom_range(0, PoolSize - 1)];
        end else if (r < 92) begin
          m = mac_pool[$urandom_range(0, PoolSize - 1)];
          m[$urandom_range(0, msfe_pkg::MacW - 1)] ^= 1'b1;
        end else begin
          m = msfe_pkg::MacW'({$urandom(), $urandom()});
        end
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
          rq.op = msfe_pkg::OP_ADD;
        end else begin
          r = $urandom_range(0, 9);
          rq.op = (r < 6) ? msfe_pkg::OP_REMOVE : (r < 9) ? msfe_pkg::OP_QUERY : OpUnused;
        end
        rq.mac = m;
        issue(rq, 1'b0, no_rsp, pick_gap(quiet));
      end
    end

    // Drain and settle
    start <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (16) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/msfe_pkg.sv
rtl/msfe_ram.sv
rtl/msfe_ctrl.sv
rtl/msfe_dpath.sv
rtl/mac_set_fifo_evict_unit.sv
dv/tb_mac_set_fifo_evict_unit.sv
